/* design/trfc_pkg.sv */
package trfc_pkg;

	// Field widths fixed by the frame format.
	localparam int BYTE_W  = 8;
	localparam int FIELD_W = 7;
	localparam int ADDR_W  = 4;
	localparam int SAPI_W  = 3;
	localparam int SUM_W   = 6;
	localparam int POS_W   = 9;
	localparam int CFG_IDX_W = 3;

	// Depth of the queue between the byte parser and the result stage.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// Byte positions within a frame; the first data byte follows source, destination and length.
	localparam logic [POS_W-1:0] POS_SRC  = 9'd0;
	localparam logic [POS_W-1:0] POS_DST  = 9'd1;
	localparam logic [POS_W-1:0] POS_LEN  = 9'd2;
	localparam logic [POS_W-1:0] POS_DATA = 9'd3;

	// Verdict codes.
	localparam logic [1:0] VERDICT_TOKEN    = 2'd0;
	localparam logic [1:0] VERDICT_CHK_ERR  = 2'd1;
	localparam logic [1:0] VERDICT_DATABACK = 2'd2;
	localparam logic [1:0] VERDICT_FORWARD  = 2'd3;

	// Status byte bits.
	localparam logic [BYTE_W-1:0] STATUS_READ     = 8'h02;
	localparam logic [BYTE_W-1:0] STATUS_READ_ACK = 8'h03;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_STATION_ADDRESS   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ALL_STATIONS_ADDR = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CHAT_SAP_NUM      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CHAT_CONNECTED    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TOKEN_MARKER      = 3'd4;

	typedef struct packed {
		logic [ADDR_W-1:0] station_address;
		logic [ADDR_W-1:0] all_stations_addr;
		logic [SAPI_W-1:0] chat_sap_num;
		logic              chat_connected;
		logic [BYTE_W-1:0] token_marker;
	} cfg_t;

	// One parsed frame, handed from the parser to the result stage.
	typedef struct packed {
		logic               is_token;
		logic               chk_ok;
		logic [BYTE_W-1:0]  status;
		logic [FIELD_W-1:0] src;
		logic [FIELD_W-1:0] dst;
	} rec_t;

endpackage

/* design/trfc_front.sv */
module trfc_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [trfc_pkg::BYTE_W-1:0]    frame_byte,
	input  logic                           frame_start,
	input  logic [trfc_pkg::BYTE_W-1:0]    token_marker,
	input  logic                           q_full,
	output logic                           push,
	output trfc_pkg::rec_t                 push_rec
);

	logic [trfc_pkg::POS_W-1:0]   pos_q, pos_d, pos_eff;
	logic [trfc_pkg::BYTE_W-1:0]  len_q, len_d;
	logic [trfc_pkg::SUM_W-1:0]   sum_q, sum_d, sum_eff;
	logic [trfc_pkg::FIELD_W-1:0] src_q, src_d, dst_q, dst_d;
	logic                         active_q, active_d;
	logic                         accept;
	logic [trfc_pkg::POS_W-1:0]   data_end;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign pos_eff  = frame_start ? '0 : pos_q;
	assign sum_eff  = frame_start ? '0 : sum_q;
	assign data_end = trfc_pkg::POS_DATA + {1'b0, len_q};

	always_comb begin
		pos_d    = pos_q;
		len_d    = len_q;
		sum_d    = sum_q;
		src_d    = src_q;
		dst_d    = dst_q;
		active_d = active_q;
		push     = 1'b0;
		push_rec = '0;
		if (accept && (frame_start || active_q)) begin
			active_d = 1'b1;
			pos_d    = pos_eff;
			sum_d    = sum_eff;
			if (pos_eff == trfc_pkg::POS_SRC) begin
				if (frame_byte == token_marker) begin
					src_d             = '0;
					active_d          = 1'b0;
					push              = 1'b1;
					push_rec.is_token = 1'b1;
				end else begin
					src_d = frame_byte[trfc_pkg::FIELD_W-1:0];
					pos_d = trfc_pkg::POS_DST;
				end
			end else if (pos_eff == trfc_pkg::POS_DST) begin
				dst_d = frame_byte[trfc_pkg::FIELD_W-1:0];
				pos_d = trfc_pkg::POS_LEN;
			end else if (pos_eff == trfc_pkg::POS_LEN) begin
				len_d = frame_byte;
				pos_d = trfc_pkg::POS_DATA;
			end else if (pos_eff < data_end) begin
				sum_d = sum_eff + frame_byte[trfc_pkg::SUM_W-1:0];
				pos_d = pos_eff + 1'b1;
			end else begin
				// Status byte closes the frame.
				active_d        = 1'b0;
				push            = 1'b1;
				push_rec.chk_ok = (sum_eff == frame_byte[7:2]);
				push_rec.status = frame_byte;
				push_rec.src    = src_q;
				push_rec.dst    = dst_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			len_q    <= '0;
			sum_q    <= '0;
			src_q    <= '0;
			dst_q    <= '0;
			active_q <= 1'b0;
		end else begin
			pos_q    <= pos_d;
			len_q    <= len_d;
			sum_q    <= sum_d;
			src_q    <= src_d;
			dst_q    <= dst_d;
			active_q <= active_d;
		end
	end

endmodule

/* design/trfc_queue.sv */
module trfc_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  trfc_pkg::rec_t push_rec,
	output logic           full,
	input  logic           pop,
	output logic           q_valid,
	output trfc_pkg::rec_t pop_rec
);

	trfc_pkg::rec_t                  mem_q [trfc_pkg::QUEUE_DEPTH];
	logic [trfc_pkg::QPTR_W-1:0]     wr_ptr_q, rd_ptr_q;
	logic [trfc_pkg::QCNT_W-1:0]     count_q;
	logic                            do_push, do_pop;

	localparam logic [trfc_pkg::QPTR_W-1:0] PTR_LAST = trfc_pkg::QPTR_W'(trfc_pkg::QUEUE_DEPTH - 1);
	localparam logic [trfc_pkg::QCNT_W-1:0] CNT_FULL = trfc_pkg::QCNT_W'(trfc_pkg::QUEUE_DEPTH);

	assign full    = (count_q == CNT_FULL);
	assign q_valid = (count_q != '0);
	assign do_push = push && !full;
	assign do_pop  = pop && q_valid;
	assign pop_rec = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* design/trfc_back.sv */
module trfc_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  trfc_pkg::cfg_t                cfg,
	input  logic                          q_valid,
	input  trfc_pkg::rec_t                rec,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    verdict,
	output logic                          deliver,
	output logic                          deliver_to_chat,
	output logic [trfc_pkg::BYTE_W-1:0]   new_status_byte,
	output logic [trfc_pkg::ADDR_W-1:0]   source_address,
	output logic [trfc_pkg::SAPI_W-1:0]   source_sapi
);

	logic                          out_valid_q;
	logic [1:0]                    verdict_q, verdict_d;
	logic                          deliver_q, deliver_d;
	logic                          chat_q, chat_d;
	logic [trfc_pkg::BYTE_W-1:0]   status_q, status_d;
	logic [trfc_pkg::ADDR_W-1:0]   src_addr_q, src_addr;
	logic [trfc_pkg::SAPI_W-1:0]   src_sapi_q;
	logic [trfc_pkg::ADDR_W-1:0]   dst_addr;
	logic                          addressed;

	assign pop      = q_valid && (!out_valid_q || !out_stall);
	assign src_addr = rec.src[6:3];
	assign dst_addr = rec.dst[6:3];
	assign addressed = (dst_addr == cfg.station_address) ||
		(dst_addr == cfg.all_stations_addr);

	always_comb begin
		verdict_d = trfc_pkg::VERDICT_TOKEN;
		deliver_d = 1'b0;
		chat_d    = 1'b0;
		status_d  = '0;
		if (!rec.is_token) begin
			if (!rec.chk_ok) begin
				verdict_d = trfc_pkg::VERDICT_CHK_ERR;
				status_d  = rec.status | trfc_pkg::STATUS_READ;
			end else begin
				verdict_d = (src_addr == cfg.station_address) ?
					trfc_pkg::VERDICT_DATABACK : trfc_pkg::VERDICT_FORWARD;
				status_d = rec.status;
				if (addressed) begin
					deliver_d = 1'b1;
					status_d  = rec.status | trfc_pkg::STATUS_READ_ACK;
					chat_d    = (rec.dst[trfc_pkg::SAPI_W-1:0] == cfg.chat_sap_num) &&
						cfg.chat_connected;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			verdict_q  <= verdict_d;
			deliver_q  <= deliver_d;
			chat_q     <= chat_d;
			status_q   <= status_d;
			src_addr_q <= src_addr;
			src_sapi_q <= rec.src[trfc_pkg::SAPI_W-1:0];
		end
	end

	assign out_valid       = out_valid_q;
	assign verdict         = verdict_q;
	assign deliver         = deliver_q;
	assign deliver_to_chat = chat_q;
	assign new_status_byte = status_q;
	assign source_address  = src_addr_q;
	assign source_sapi     = src_sapi_q;

endmodule

/* design/token_ring_frame_receive_classifier_core.sv */
// Throughput: one frame byte per clock cycle while in_stall is low.
// A verdict for a token byte or status byte passes through a queue entry and then the
// output register before it appears on the result outputs; the parser and the result stage
// are parted by a two-entry queue, so input stalls only when that queue is full.
// Reset (arst_n, asynchronous, active low) clears the parser, the queue and the output
// valid, and loads the configuration registers with their defaults.
module token_ring_frame_receive_classifier_core (
	input  logic                               clk,
	input  logic                               arst_n,
	// Configuration write port.
	input  logic                               cfg_write,
	input  logic [trfc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [trfc_pkg::BYTE_W-1:0]        cfg_data,
	// Input channel: one frame byte per transfer.
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [trfc_pkg::BYTE_W-1:0]        frame_byte,
	input  logic                               frame_start,
	// Output channel: one verdict per transfer.
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [1:0]                         verdict,
	output logic                               deliver,
	output logic                               deliver_to_chat,
	output logic [trfc_pkg::BYTE_W-1:0]        new_status_byte,
	output logic [trfc_pkg::ADDR_W-1:0]        source_address,
	output logic [trfc_pkg::SAPI_W-1:0]        source_sapi
);

	// Configuration registers. Writes must arrive only while the block is idle (the block
	// itself does not enforce this), so both the parser and the result stage may read them directly.
	trfc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.station_address   <= 4'd0;
			cfg_q.all_stations_addr <= 4'd15;
			cfg_q.chat_sap_num      <= 3'd1;
			cfg_q.chat_connected    <= 1'b0;
			cfg_q.token_marker      <= 8'd255;
		end else if (cfg_write) begin
			case (cfg_index)
				trfc_pkg::REG_STATION_ADDRESS: begin
					cfg_q.station_address <= cfg_data[trfc_pkg::ADDR_W-1:0];
				end
				trfc_pkg::REG_ALL_STATIONS_ADDR: begin
					cfg_q.all_stations_addr <= cfg_data[trfc_pkg::ADDR_W-1:0];
				end
				trfc_pkg::REG_CHAT_SAP_NUM: begin
					cfg_q.chat_sap_num <= cfg_data[trfc_pkg::SAPI_W-1:0];
				end
				trfc_pkg::REG_CHAT_CONNECTED: begin
					cfg_q.chat_connected <= cfg_data[0];
				end
				trfc_pkg::REG_TOKEN_MARKER: begin
					cfg_q.token_marker <= cfg_data;
				end
				default: begin
					// Writes to unused indexes are dropped.
				end
			endcase
		end
	end

	// The front end tracks the byte position within a frame, captures the
	// header fields and keeps the running checksum. When a frame closes (a
	// token byte or a status byte) it pushes one record into the queue.
	logic           q_full;
	logic           q_push;
	logic           q_pop;
	logic           q_valid;
	trfc_pkg::rec_t push_rec;
	trfc_pkg::rec_t pop_rec;

	trfc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.frame_byte  (frame_byte),
		.frame_start (frame_start),
		.token_marker(cfg_q.token_marker),
		.q_full      (q_full),
		.push        (q_push),
		.push_rec    (push_rec)
	);

	trfc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_rec(push_rec),
		.full    (q_full),
		.pop     (q_pop),
		.q_valid (q_valid),
		.pop_rec (pop_rec)
	);

	// The back end resolves addressing and delivery for the oldest record and
	// holds the result in an output register until the transfer completes.
	trfc_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.q_valid        (q_valid),
		.rec            (pop_rec),
		.pop            (q_pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.verdict        (verdict),
		.deliver        (deliver),
		.deliver_to_chat(deliver_to_chat),
		.new_status_byte(new_status_byte),
		.source_address (source_address),
		.source_sapi    (source_sapi)
	);

`ifndef SYNTHESIS
	// The parser never closes a frame while the queue has no room.
	assert property (@(posedge clk) disable iff (!arst_n) q_push |-> !q_full)
		else $error("frame record pushed into a full queue");

	// Delivery only follows a good checksum on a data frame.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && deliver) |->
		(verdict == trfc_pkg::VERDICT_DATABACK || verdict == trfc_pkg::VERDICT_FORWARD))
		else $error("delivery flagged on a token or checksum error");

	// Chat delivery is a kind of delivery.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && deliver_to_chat) |-> deliver)
		else $error("chat delivery without delivery");

	// A token result carries no status and no source.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && verdict == trfc_pkg::VERDICT_TOKEN) |->
		(new_status_byte == '0 && source_address == '0 && source_sapi == '0))
		else $error("token result with nonzero fields");
`endif

endmodule
